### rtl/rbfn_pkg.sv
// Shared types, constants and the exp table generator for the RBF network evaluator.
package rbfn_pkg;

	localparam int MAX_NEURONS_DEF = 64;
	localparam int EXP_DEPTH_DEF   = 256;
	localparam int COORD_W         = 16;
	localparam int CENTER_W        = 3 * COORD_W;
	localparam int ACT_W           = 17;
	localparam int NC_W            = 7;
	localparam int INV_W           = 24;
	localparam int PIPE_DRAIN      = 10;

	typedef enum logic [1:0] {
		CMD_LOAD_CENTER = 2'd0,
		CMD_LOAD_WEIGHT = 2'd1,
		CMD_EVAL        = 2'd2
	} cmd_t;

	localparam logic CFG_NEURON_COUNT = 1'b0;
	localparam logic CFG_INV_WIDTH    = 1'b1;

	typedef struct packed {
		logic        done;
		logic [15:0] pred;
		logic        zero;
	} div_res_t;

	// shift-and-subtract quotient, used only while building the table
	function automatic longint unsigned udiv64(input longint unsigned a,
			input longint unsigned b);
		longint unsigned q;
		longint unsigned r;
		q = '0;
		r = '0;
		for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
			r = {r[62:0], a[bit_pos]};
			q = {q[62:0], 1'b0};
			if (r >= b) begin
				r = r - b;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-16*i/depth) in Q1.16, built from a Q1.31 Taylor series squared four times
	function automatic logic [ACT_W-1:0] exp_entry(input int unsigned i,
			input int unsigned depth);
		longint unsigned one;
		longint unsigned g;
		longint unsigned s;
		longint unsigned term;
		longint unsigned r;
		one = 64'd1 << 31;
		g = udiv64({32'd0, i} << 31, {32'd0, depth});
		s = one;
		term = one;
		for (int k = 1; k <= 20; k++) begin
			term = udiv64((term * g) >> 31, longint'(k));
			if ((k & 1) == 1)
				s = s - term;
			else
				s = s + term;
		end
		for (int k = 0; k < 4; k++)
			s = (s * s + (64'd1 << 30)) >> 31;
		r = (s + (64'd1 << 14)) >> 15;
		return r[ACT_W-1:0];
	endfunction

endpackage

### rtl/rbfn_cell.sv
// One neuron slot of the rotating center and weight ring.
module rbfn_cell #(
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          shift,
	input  logic                          load_c,
	input  logic                          load_w,
	input  logic [5:0]                    load_idx,
	input  logic [rbfn_pkg::CENTER_W-1:0] c_load,
	input  logic [15:0]                   w_load,
	input  logic [rbfn_pkg::CENTER_W-1:0] c_nb,
	input  logic [15:0]                   w_nb,
	output logic [rbfn_pkg::CENTER_W-1:0] c_q,
	output logic [15:0]                   w_q
);

	logic hit;
	assign hit = ({26'd0, load_idx} == 32'(IDX));

	always_ff @(posedge clk) begin
		if (shift) begin
			c_q <= c_nb;
			w_q <= w_nb;
		end else begin
			if (load_c && hit)
				c_q <= c_load;
			if (load_w && hit)
				w_q <= w_load;
		end
	end

endmodule

### rtl/rbfn_acc.sv
// Activation pipeline: distance, scaling, exp lookup and weighted accumulation.
module rbfn_acc #(
	parameter int MAX_NEURONS     = rbfn_pkg::MAX_NEURONS_DEF,
	parameter int EXP_TABLE_DEPTH = rbfn_pkg::EXP_DEPTH_DEF,
	parameter int NUMW            = 33 + $clog2(MAX_NEURONS + 1),
	parameter int DENW            = rbfn_pkg::ACT_W + $clog2(MAX_NEURONS + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clear,
	input  logic                              issue,
	input  logic [rbfn_pkg::CENTER_W-1:0]     center,
	input  logic signed [15:0]                weight,
	input  logic signed [15:0]                pt [3],
	input  logic [rbfn_pkg::INV_W-1:0]        inv,
	output logic signed [NUMW-1:0]            num_q,
	output logic [DENW-1:0]                   den_q
);

	localparam int DW = $clog2(EXP_TABLE_DEPTH + 1);
	localparam int TW = $clog2(EXP_TABLE_DEPTH);
	localparam int AW = rbfn_pkg::ACT_W;

	logic [AW-1:0] tab [EXP_TABLE_DEPTH];
	for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_tab
		assign tab[gi] = rbfn_pkg::exp_entry(gi, EXP_TABLE_DEPTH);
	end

	logic [8:0] v_q;
	logic signed [15:0] w_s1, w_s2, w_s3, w_s4, w_s5, w_s6, w_s7, w_s8;
	logic [15:0] mag_s1 [3];
	logic [31:0] sq_s2 [3];
	logic [33:0] sum_s3;
	logic [45:0] plo_s4, phi_s4;
	logic [57:0] x_s5;
	logic [18+DW-1:0] xh_s6, xl_s6;
	logic inr_s6, inr_s7;
	logic [TW-1:0] idx_s7;
	logic [AW-1:0] act_s8, act_s9;
	logic signed [32:0] prod_s9;
	logic [36+DW:0] ix_sum;

	assign ix_sum = {1'b0, xh_s6, 18'd0} + {19'd0, xl_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else
			v_q <= {v_q[7:0], issue};
	end

	always_ff @(posedge clk) begin
		for (int d = 0; d < 3; d++) begin
			logic signed [16:0] diff;
			diff = 17'($signed(center[16*d +: 16])) - 17'(pt[d]);
			mag_s1[d] <= diff[16] ? 16'(-diff) : diff[15:0];
			sq_s2[d] <= mag_s1[d] * mag_s1[d];
		end
		sum_s3 <= 34'(sq_s2[0]) + 34'(sq_s2[1]) + 34'(sq_s2[2]);
		plo_s4 <= sum_s3 * inv[11:0];
		phi_s4 <= sum_s3 * inv[23:12];
		x_s5 <= 58'(plo_s4) + {phi_s4, 12'd0};
		inr_s6 <= (x_s5[57:36] == '0);
		xh_s6 <= x_s5[35:18] * DW'(EXP_TABLE_DEPTH);
		xl_s6 <= x_s5[17:0] * DW'(EXP_TABLE_DEPTH);
		inr_s7 <= inr_s6;
		idx_s7 <= ix_sum[36 +: TW];
		act_s8 <= inr_s7 ? tab[idx_s7] : '0;
		act_s9 <= act_s8;
		prod_s9 <= $signed({1'b0, act_s8}) * w_s8;
		w_s1 <= weight;
		w_s2 <= w_s1;
		w_s3 <= w_s2;
		w_s4 <= w_s3;
		w_s5 <= w_s4;
		w_s6 <= w_s5;
		w_s7 <= w_s6;
		w_s8 <= w_s7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			den_q <= '0;
		end else if (clear) begin
			num_q <= '0;
			den_q <= '0;
		end else if (v_q[8]) begin
			num_q <= num_q + NUMW'(prod_s9);
			den_q <= den_q + DENW'(act_s9);
		end
	end

endmodule

### rtl/rbfn_div.sv
// Restoring divider with rounding and Q8.8 saturation for the normalized output.
module rbfn_div #(
	parameter int NUMW = 40,
	parameter int DENW = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic signed [NUMW-1:0] num,
	input  logic [DENW-1:0]        den,
	output rbfn_pkg::div_res_t     res
);

	localparam int CW = $clog2(NUMW + 1);

	logic busy_q, fin_q, neg_q, zero_q;
	logic [CW-1:0] cnt_q;
	logic [NUMW-1:0] dvd_q;
	logic [DENW-1:0] rem_q, den_q;
	logic [DENW:0] rem2;
	logic ge;
	logic [NUMW-1:0] mag;

	assign mag = num[NUMW-1] ? $unsigned(-num) : $unsigned(num);
	assign rem2 = {rem_q, dvd_q[NUMW-1]};
	assign ge = (rem2 >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= (den != '0);
				fin_q <= (den == '0);
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(NUMW - 1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUMW-1];
			zero_q <= (den == '0);
			den_q <= den;
			dvd_q <= mag + NUMW'(den >> 1);
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DENW'(rem2 - {1'b0, den_q}) : rem2[DENW-1:0];
			dvd_q <= {dvd_q[NUMW-2:0], ge};
		end
	end

	always_comb begin
		res.done = fin_q;
		res.zero = zero_q;
		if (zero_q)
			res.pred = '0;
		else if (!neg_q)
			res.pred = (dvd_q > NUMW'(32767)) ? 16'h7FFF : dvd_q[15:0];
		else
			res.pred = (dvd_q > NUMW'(32768)) ? 16'h8000 : 16'(-dvd_q[15:0]);
	end

endmodule

### rtl/rbf_network_inference_top.sv
// Normalized Gaussian RBF network evaluator for 3-D points.
//
// Input channel (in_valid/in_stall): a word carries a command. Load center and
// load weight write the addressed neuron slot and give no result.
// Evaluate walks a ring of MAX_NEURONS cells that rotates once, one neuron a
// cycle, feeding a 10-stage activation pipeline, then runs a one-bit-a-cycle
// divider over the numerator width (33 + clog2(MAX_NEURONS+1) bits).
// An evaluate always rotates the full ring, whatever neuron_count is. in_stall
// is high while an evaluation is in flight.
// Output channel (out_valid/out_stall): one word per evaluate, held in an
// output register; a new input word is taken while it waits. If the receiver
// stalls and a second result finishes, the block holds it until the first
// is taken.
// Config: cfg_we writes cfg_data to register cfg_index; the user must write
// only while idle, and the block itself does not enforce it. Reset clears
// control state and the registers to neuron_count 1 and inv_two_width_sq 1.0;
// neuron stores are undefined until loaded.
module rbf_network_inference_top #(
	parameter int MAX_NEURONS     = rbfn_pkg::MAX_NEURONS_DEF,
	parameter int EXP_TABLE_DEPTH = rbfn_pkg::EXP_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic [5:0]         neuron_index,
	input  logic signed [15:0] coord_0,
	input  logic signed [15:0] coord_1,
	input  logic signed [15:0] coord_2,
	input  logic signed [15:0] weight_value,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] prediction,
	output logic               zero_activation,
	output logic               last_of_batch,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [23:0]        cfg_data
);

	localparam int CW   = $clog2(MAX_NEURONS + 1);
	localparam int NUMW = 33 + CW;
	localparam int DENW = rbfn_pkg::ACT_W + CW;

	typedef enum logic [2:0] {ST_IDLE, ST_ROT, ST_DRAIN, ST_DIV, ST_HOLD} state_t;

	state_t state_q;
	logic [CW-1:0] rot_q;
	logic [3:0] drain_q;
	logic [rbfn_pkg::NC_W-1:0] nc_q;
	logic [rbfn_pkg::INV_W-1:0] inv_q;
	logic signed [15:0] pt_q [3];
	logic last_q;
	logic [CW-1:0] cnt_eff;
	logic accept, is_eval, shift, div_start, out_load;
	logic signed [NUMW-1:0] num;
	logic [DENW-1:0] den;
	rbfn_pkg::div_res_t dres;
	logic [rbfn_pkg::CENTER_W-1:0] cc [MAX_NEURONS];
	logic [15:0] cwt [MAX_NEURONS];

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && !in_stall;
	assign is_eval = accept && (command == rbfn_pkg::CMD_EVAL);
	assign shift = (state_q == ST_ROT);
	assign div_start = (state_q == ST_DRAIN) && (drain_q == 4'(rbfn_pkg::PIPE_DRAIN - 1));
	assign cnt_eff = ({25'd0, nc_q} > 32'(MAX_NEURONS)) ? CW'(MAX_NEURONS) : CW'(nc_q);
	assign out_load = (state_q == ST_HOLD) && (!out_valid || !out_stall);

	for (genvar gi = 0; gi < MAX_NEURONS; gi++) begin : g_cell
		localparam int NB = (gi + 1) % MAX_NEURONS;
		rbfn_cell #(.IDX(gi)) u_cell (
			.clk      (clk),
			.shift    (shift),
			.load_c   (accept && command == rbfn_pkg::CMD_LOAD_CENTER),
			.load_w   (accept && command == rbfn_pkg::CMD_LOAD_WEIGHT),
			.load_idx (neuron_index),
			.c_load   ({coord_2, coord_1, coord_0}),
			.w_load   (weight_value),
			.c_nb     (cc[NB]),
			.w_nb     (cwt[NB]),
			.c_q      (cc[gi]),
			.w_q      (cwt[gi])
		);
	end

	rbfn_acc #(
		.MAX_NEURONS     (MAX_NEURONS),
		.EXP_TABLE_DEPTH (EXP_TABLE_DEPTH),
		.NUMW            (NUMW),
		.DENW            (DENW)
	) u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (is_eval),
		.issue  (shift && (rot_q < cnt_eff)),
		.center (cc[0]),
		.weight ($signed(cwt[0])),
		.pt     (pt_q),
		.inv    (inv_q),
		.num_q  (num),
		.den_q  (den)
	);

	rbfn_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num),
		.den    (den),
		.res    (dres)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= rbfn_pkg::NC_W'(1);
			inv_q <= rbfn_pkg::INV_W'(65536);
		end else if (cfg_we) begin
			if (cfg_index == rbfn_pkg::CFG_NEURON_COUNT)
				nc_q <= cfg_data[rbfn_pkg::NC_W-1:0];
			else
				inv_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (is_eval) begin
			pt_q[0] <= coord_0;
			pt_q[1] <= coord_1;
			pt_q[2] <= coord_2;
			last_q <= last_point;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rot_q <= '0;
			drain_q <= '0;
			out_valid <= 1'b0;
			prediction <= '0;
			zero_activation <= 1'b0;
			last_of_batch <= 1'b0;
		end else begin
			if (out_load)
				out_valid <= 1'b1;
			else if (out_valid && !out_stall)
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (is_eval) begin
						state_q <= ST_ROT;
						rot_q <= '0;
					end
				end
				ST_ROT: begin
					rot_q <= rot_q + 1'b1;
					if (rot_q == CW'(MAX_NEURONS - 1)) begin
						state_q <= ST_DRAIN;
						drain_q <= '0;
					end
				end
				ST_DRAIN: begin
					drain_q <= drain_q + 1'b1;
					if (div_start)
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dres.done)
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					// hand the result over once the output register is free
					if (out_load) begin
						prediction <= $signed(dres.pred);
						zero_activation <= dres.zero;
						last_of_batch <= last_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROT |-> rot_q < CW'(MAX_NEURONS))
		else $error("ring counter past last cell");

	a_div_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		dres.done |-> state_q == ST_DIV)
		else $error("divider finished outside divide phase");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(prediction))
		else $error("stalled result word changed");

	a_rot_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		is_eval |=> state_q == ST_ROT && rot_q == '0)
		else $error("evaluate word did not start ring walk");

endmodule

### tb/rbf_network_inference_top_tb.sv
// Testbench for the RBF network evaluator: random load/evaluate traffic against a predictor.
`timescale 1ns / 100ps

module rbf_network_inference_top_tb;

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [5:0]         idx;
		logic signed [15:0] c0;
		logic signed [15:0] c1;
		logic signed [15:0] c2;
		logic signed [15:0] w;
		logic               lp;
	} rbf_word_t;

	typedef struct packed {
		logic signed [15:0] pred;
		logic               zero;
		logic               last;
	} rbf_out_t;

	class rbf_scoreboard;
		int              ctr[64][3];
		int              wgt[64];
		int unsigned     count;
		int unsigned     inv;
		longint unsigned lut[256];
		rbf_out_t        pending[$];
		int              fails;

		function new();
			longint unsigned one, g, s, term;
			one = 64'd1 << 31;
			for (int i = 0; i < 256; i++) begin
				g = (longint'(i) << 31) / 256;
				s = one;
				term = one;
				for (int k = 1; k <= 20; k++) begin
					term = ((term * g) >> 31) / longint'(k);
					if (k % 2 == 1)
						s = s - term;
					else
						s = s + term;
				end
				for (int k = 0; k < 4; k++)
					s = (s * s + (64'd1 << 30)) >> 31;
				lut[i] = (s + (64'd1 << 14)) >> 15;
			end
			count = 1;
			inv = 65536;
			fails = 0;
		endfunction

		function void set_count(int unsigned v);
			count = v & 7'h7f;
		endfunction

		function void set_inv(int unsigned v);
			inv = v & 24'hffffff;
		endfunction

		function void note_input(rbf_word_t wd);
			int              n_used;
			int              p[3];
			longint unsigned den, dsum, x, act, mag, q;
			longint          num, pred, diff;
			rbf_out_t        r;
			p[0] = wd.c0;
			p[1] = wd.c1;
			p[2] = wd.c2;
			unique case (wd.cmd)
				rbfn_pkg::CMD_LOAD_CENTER: begin
					for (int d = 0; d < 3; d++)
						ctr[wd.idx][d] = p[d];
				end
				rbfn_pkg::CMD_LOAD_WEIGHT: begin
					wgt[wd.idx] = wd.w;
				end
				rbfn_pkg::CMD_EVAL: begin
					n_used = count > 64 ? 64 : count;
					den = 0;
					num = 0;
					for (int n = 0; n < n_used; n++) begin
						dsum = 0;
						for (int d = 0; d < 3; d++) begin
							diff = longint'(ctr[n][d]) - longint'(p[d]);
							if (diff < 0)
								diff = -diff;
							dsum += longint'(diff) * longint'(diff);
						end
						x = dsum * longint'(inv);
						act = 0;
						if (x < (64'd16 << 32))
							act = lut[(x * 256) >> 36];
						den += act;
						num += longint'(act) * longint'(wgt[n]);
					end
					r.zero = (den == 0);
					if (r.zero) begin
						pred = 0;
					end else begin
						mag = num < 0 ? -num : num;
						q = (mag + den / 2) / den;
						if (q > 40000)
							q = 40000;
						pred = num < 0 ? -longint'(q) : longint'(q);
						if (pred > 32767)
							pred = 32767;
						if (pred < -32768)
							pred = -32768;
					end
					r.pred = pred[15:0];
					r.last = wd.lp;
					pending.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic signed [15:0] pred, logic zero, logic last);
			rbf_out_t e;
			if (pending.size() == 0) begin
				$error("unexpected result word: prediction %0d", pred);
				fails++;
				return;
			end
			e = pending.pop_front();
			if (pred !== e.pred) begin
				$error("prediction: expected %0d, got %0d", e.pred, pred);
				fails++;
			end
			if (zero !== e.zero) begin
				$error("zero_activation: expected %0b, got %0b", e.zero, zero);
				fails++;
			end
			if (last !== e.last) begin
				$error("last_of_batch: expected %0b, got %0b", e.last, last);
				fails++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         command;
	logic [5:0]         neuron_index;
	logic signed [15:0] coord_0;
	logic signed [15:0] coord_1;
	logic signed [15:0] coord_2;
	logic signed [15:0] weight_value;
	logic               last_point;
	logic               out_valid;
	logic               out_stall;
	logic signed [15:0] prediction;
	logic               zero_activation;
	logic               last_of_batch;
	logic               cfg_we;
	logic               cfg_index;
	logic [23:0]        cfg_data;

	rbf_network_inference_top uut (.*);

	rbf_scoreboard sb;
	bit            tx_idle;
	bit            rx_idle;
	bit            hold_req;
	bit            hold_used;
	int            hold_left;
	int            quiet_cycles;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 200;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(5, 40);
	endfunction

	// entered and left at a falling edge
	task automatic send_word(rbf_word_t wd);
		int gap;
		gap = tx_idle ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command      <= wd.cmd;
		neuron_index <= wd.idx;
		coord_0      <= wd.c0;
		coord_1      <= wd.c1;
		coord_2      <= wd.c2;
		weight_value <= wd.w;
		last_point   <= wd.lp;
		in_valid     <= 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		sb.note_input(wd);
		@(negedge clk);
	endtask

	function automatic rbf_word_t make_word(logic [1:0] cmd, int idx, int c0, int c1, int c2,
			int w, bit lp);
		rbf_word_t wd;
		wd.cmd = cmd;
		wd.idx = idx[5:0];
		wd.c0 = c0[15:0];
		wd.c1 = c1[15:0];
		wd.c2 = c2[15:0];
		wd.w = w[15:0];
		wd.lp = lp;
		return wd;
	endfunction

	function automatic int near_coord(int base, int spread);
		int v;
		v = base + $signed($urandom_range(0, 2 * spread)) - spread;
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		return v;
	endfunction

	function automatic int region_coord();
		return ($urandom_range(0, 9) == 0) ? $signed(16'($urandom)) :
			$signed($urandom_range(0, 4095)) - 2048;
	endfunction

	function automatic rbf_word_t random_word();
		int sel, n, spread;
		sel = $urandom_range(0, 99);
		n = $urandom_range(0, 63);
		if (sel < 20)
			return make_word(rbfn_pkg::CMD_LOAD_CENTER, n, region_coord(), region_coord(),
				region_coord(), $urandom, $urandom_range(0, 1));
		if (sel < 35)
			return make_word(rbfn_pkg::CMD_LOAD_WEIGHT, n, $urandom, $urandom, $urandom,
				$signed(16'($urandom)), $urandom_range(0, 1));
		if (sel < 95) begin
			if ($urandom_range(0, 9) == 0)
				return make_word(rbfn_pkg::CMD_EVAL, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom_range(0, 1));
			spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 600);
			return make_word(rbfn_pkg::CMD_EVAL, $urandom, near_coord(sb.ctr[n][0], spread),
				near_coord(sb.ctr[n][1], spread), near_coord(sb.ctr[n][2], spread),
				$urandom, $urandom_range(0, 1));
		end
		return make_word(CMD_UNKNOWN, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom_range(0, 1));
	endfunction

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_cfg(logic idx, int unsigned value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[23:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == rbfn_pkg::CFG_NEURON_COUNT)
			sb.set_count(value);
		else
			sb.set_inv(value);
	endtask

	// receiver side: random stall, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_used) begin
			out_stall <= 1'b1;
			hold_left <= 400;
			hold_used <= 1'b1;
		end else begin
			out_stall <= rx_idle ? ($urandom_range(0, 9) < 3) : 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(prediction, zero_activation, last_of_batch);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned counts[8];
		int unsigned invs[8];
		rbf_word_t   wd;
		sb = new();
		counts = '{1, 64, 0, 127, 3, 20, 64, 8};
		invs   = '{65536, 65536, 65536, 0, 24'hffffff, 1, 4096, 300000};
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = rbfn_pkg::CMD_EVAL;
		neuron_index = '0;
		coord_0 = '0;
		coord_1 = '0;
		coord_2 = '0;
		weight_value = '0;
		last_point = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rbfn_pkg::CFG_NEURON_COUNT;
		cfg_data = '0;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_req = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// fill every slot so no evaluation touches an unwritten entry
		for (int n = 0; n < 64; n++) begin
			send_word(make_word(rbfn_pkg::CMD_LOAD_CENTER, n, region_coord(), region_coord(),
				region_coord(), 0, 0));
			send_word(make_word(rbfn_pkg::CMD_LOAD_WEIGHT, n, 0, 0, 0,
				$signed(16'($urandom)), 0));
		end

		// directed: extremes, unknown command, exact hits
		send_word(make_word(rbfn_pkg::CMD_LOAD_WEIGHT, 0, 0, 0, 0, 32767, 0));
		send_word(make_word(rbfn_pkg::CMD_LOAD_CENTER, 0, 0, 0, 0, 0, 1));
		send_word(make_word(rbfn_pkg::CMD_EVAL, 0, 0, 0, 0, 0, 1));
		send_word(make_word(rbfn_pkg::CMD_EVAL, 63, 32767, 32767, 32767, -1, 0));
		send_word(make_word(rbfn_pkg::CMD_EVAL, 0, -32768, -32768, -32768, 0, 1));
		send_word(make_word(CMD_UNKNOWN, 63, -1, -1, -1, -1, 1));
		send_word(make_word(rbfn_pkg::CMD_LOAD_WEIGHT, 0, 0, 0, 0, -32768, 0));
		send_word(make_word(rbfn_pkg::CMD_EVAL, 0, 100, -100, 50, 0, 0));
		send_word(make_word(rbfn_pkg::CMD_LOAD_CENTER, 0, 32767, -32768, 32767, 0, 0));
		send_word(make_word(rbfn_pkg::CMD_EVAL, 0, 32767, -32768, 32767, 0, 1));
		send_word(make_word(rbfn_pkg::CMD_LOAD_WEIGHT, 63, 0, 0, 0, 32767, 1));
		send_word(make_word(rbfn_pkg::CMD_LOAD_CENTER, 63, -32768, 32767, -32768, 0, 1));

		for (int ph = 0; ph < 8; ph++) begin
			wait_idle();
			write_cfg(rbfn_pkg::CFG_NEURON_COUNT, counts[ph]);
			write_cfg(rbfn_pkg::CFG_INV_WIDTH, invs[ph]);
			send_word(make_word(rbfn_pkg::CMD_EVAL, 0, sb.ctr[0][0], sb.ctr[0][1],
				sb.ctr[0][2], 0, 1));
			send_word(make_word(rbfn_pkg::CMD_EVAL, 0, sb.ctr[63][0], sb.ctr[63][1],
				sb.ctr[63][2], 0, 0));
			tx_idle = (ph % 3 != 1);
			rx_idle = (ph % 4 != 2);
			if (ph == 4)
				hold_req = 1'b1;
			for (int i = 0; i < 180; i++) begin
				wd = random_word();
				send_word(wd);
			end
		end

		wait_idle();
		if (sb.fails == 0 && sb.pending.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
